>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the spectrum bin shift block
// Shared implication checks, all clocked and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when pre holds, post must hold in that cycle.
`define SCBS_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication: when pre holds, post must hold in the next cycle.
`define SCBS_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/scbs_pkg.sv
// ---------------------------------------------------------------------------
// scbs_pkg
// Types, constants and codes shared by the spectrum bin shift modules.
// ---------------------------------------------------------------------------
`default_nettype none

package scbs_pkg;

    // Store geometry and sample format.
    localparam int MAX_BINS    = 1024;
    localparam int BIN_W       = $clog2(MAX_BINS);
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_W       = 11;
    localparam int SHIFT_W     = 10;
    localparam int MODE_W      = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_BINS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd2;

    // Operation codes of an input request.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Mode codes; bit 1 set selects the cosine average.
    localparam logic [MODE_W-1:0] MODE_FWD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BWD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(MAX_BINS);
    localparam logic [SHIFT_W-1:0] SHIFT_RESET  = '0;

    typedef struct packed {
        logic                          op;
        logic [BIN_W-1:0]              bin_index;
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_re;
        logic signed [SAMPLE_BITS-1:0] out_im;
        logic                          error;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the accepted request
        logic issue;     // write the bin or read the store
        logic finish;    // load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/scbs_datapath.sv
// ---------------------------------------------------------------------------
// scbs_datapath
// Configuration registers, bin store with two read ports, index arithmetic
// and the output register of the spectrum bin shift block.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scbs_datapath
    import scbs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_in_item              i_item,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    output t_out_item                  o_result
);

    localparam int IDX_W = WIN_W + 1;

    logic [WIN_W-1:0]   r_window;
    logic [SHIFT_W-1:0] r_shift;
    logic [MODE_W-1:0]  r_mode;

    t_in_item r_item;
    logic     r_err;
    logic     r_cos;
    logic     r_bwd;

    logic [2*SAMPLE_BITS-1:0] r_mem [MAX_BINS];
    logic [2*SAMPLE_BITS-1:0] r_rd_fwd;
    logic [2*SAMPLE_BITS-1:0] r_rd_bwd;

    t_out_item r_result;
    t_out_item n_result;

    logic [IDX_W-1:0] w_win12;
    logic [IDX_W-1:0] w_k12;
    logic [IDX_W-1:0] w_s12;
    logic [IDX_W-1:0] w_fwd_raw;
    logic [IDX_W-1:0] w_bwd_raw;
    logic [IDX_W-1:0] w_fwd_full;
    logic [IDX_W-1:0] w_bwd_full;
    logic             n_err;

    logic signed [SAMPLE_BITS-1:0] w_fre, w_fim, w_bre, w_bim;
    logic signed [SAMPLE_BITS:0]   w_sum_re, w_sum_im;

    // Configuration registers; the user must write them only while idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_shift  <= SHIFT_RESET;
            r_mode   <= MODE_FWD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_SIZE: r_window <= i_cfg_data;
                CFG_SHIFT_BINS:  r_shift  <= i_cfg_data[SHIFT_W-1:0];
                CFG_MODE:        r_mode   <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Request register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    assign o_status.is_read = (r_item.op == OP_READ);

    // Source bins: forward is (k + n - s) mod n, backward is (k + s) mod n.
    // With k and s below n, one conditional subtract brings each into range.
    assign w_win12   = {1'b0, r_window};
    assign w_k12     = {{(IDX_W-BIN_W){1'b0}}, r_item.bin_index};
    assign w_s12     = {{(IDX_W-SHIFT_W){1'b0}}, r_shift};
    assign w_fwd_raw = w_k12 + w_win12 - w_s12;
    assign w_bwd_raw = w_k12 + w_s12;

    always_comb begin
        w_fwd_full = (w_fwd_raw >= w_win12) ? (w_fwd_raw - w_win12) : w_fwd_raw;
        w_bwd_full = (w_bwd_raw >= w_win12) ? (w_bwd_raw - w_win12) : w_bwd_raw;
    end

    // A read fails on a bad window size, or an index or shift outside it.
    assign n_err = (r_window < WIN_W'(2)) || (r_window > WIN_W'(MAX_BINS)) ||
                   (w_k12 >= w_win12) || (w_s12 >= w_win12);

    // Bin store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            if (r_item.op == OP_LOAD) begin
                r_mem[r_item.bin_index] <= {r_item.sample_re, r_item.sample_im};
            end
            r_rd_fwd <= r_mem[w_fwd_full[BIN_W-1:0]];
            r_rd_bwd <= r_mem[w_bwd_full[BIN_W-1:0]];
        end
    end

    // Error and mode selection travel with the read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_err <= n_err;
            r_cos <= r_mode[1];
            r_bwd <= (r_mode == MODE_BWD);
        end
    end

    // Result: one of the two bins, or the floored half-sum of both, or zero on an error.
    assign w_fre    = r_rd_fwd[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_fim    = r_rd_fwd[SAMPLE_BITS-1:0];
    assign w_bre    = r_rd_bwd[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_bim    = r_rd_bwd[SAMPLE_BITS-1:0];
    assign w_sum_re = {w_fre[SAMPLE_BITS-1], w_fre} + {w_bre[SAMPLE_BITS-1], w_bre};
    assign w_sum_im = {w_fim[SAMPLE_BITS-1], w_fim} + {w_bim[SAMPLE_BITS-1], w_bim};

    always_comb begin
        n_result.error = r_err;
        if (r_err) begin
            n_result.out_re = '0;
            n_result.out_im = '0;
        end else if (r_cos) begin
            n_result.out_re = w_sum_re[SAMPLE_BITS:1];
            n_result.out_im = w_sum_im[SAMPLE_BITS:1];
        end else if (r_bwd) begin
            n_result.out_re = w_bre;
            n_result.out_im = w_bim;
        end else begin
            n_result.out_re = w_fre;
            n_result.out_im = w_fim;
        end
    end

    // Output register; it holds while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

    `SCBS_ASSERT_IMP(a_src_in_window, i_clk, i_rst_n, i_cmd.issue && o_status.is_read && !n_err, (w_fwd_full < w_win12) && (w_bwd_full < w_win12), "source bin outside window")

endmodule

`default_nettype wire

>>> rtl/scbs_ctrl.sv
// ---------------------------------------------------------------------------
// scbs_ctrl
// Sequencer of the spectrum bin shift block: accepts one request at a time,
// steps the datapath and owns the output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scbs_ctrl
    import scbs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Commands to the datapath.
    always_comb begin
        o_cmd.capture = w_accept;
        o_cmd.issue   = (r_state == S_CALC);
        o_cmd.finish  = (r_state == S_RES) && w_out_free;
    end

    // Next state: loads end after the store write, reads after the result
    // moves into the output register.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = i_status.is_read ? S_RES : S_IDLE;
            end
            S_RES: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid sets on a new result and clears when it is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SCBS_ASSERT_NXT(a_accept_to_calc, i_clk, i_rst_n, w_accept, r_state == S_CALC, "accepted request did not reach the store step")
    `SCBS_ASSERT_NXT(a_finish_sets_valid, i_clk, i_rst_n, o_cmd.finish, r_out_valid, "finished result not presented")

endmodule

`default_nettype wire

>>> rtl/spectrum_cyclic_bin_shift.sv
// ---------------------------------------------------------------------------
// spectrum_cyclic_bin_shift
// Cyclic shift of a stored complex spectrum window: loads write bins, reads
// return the forward, backward or cosine-averaged shifted bin.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid/o_in_stall   i_in_item (op, bin, re, im)
// output    out        o_out_valid/i_out_stall o_out_item (re, im, error)
// config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// A load request passes the store step before the next acceptance, a read
// the store step and then the result step; the registered store read sets this.
// A new request is accepted while a finished result still waits in the
// output register; a read then waits only if that register is still full.
// Reset (i_rst_n low, synchronous) clears control and configuration; the
// bin store holds no reset value and must be loaded before it is read.
// ---------------------------------------------------------------------------
`default_nettype none

module spectrum_cyclic_bin_shift
    import scbs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_item
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer.
    scbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Store, index arithmetic and output register.
    scbs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (o_out_item)
    );

endmodule

`default_nettype wire

>>> verif/spectrum_cyclic_bin_shift_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spectrum_cyclic_bin_shift_tb
// Self-checking bench for the cyclic spectrum bin shift. Loads and reads are
// sent over the valid/stall input channel while a bench-side copy of the bin
// store and registers predicts each read result. Results are checked in
// order, field by field. A short directed part covers wrap-around, every
// mode and every error case. Random phases with changing registers follow,
// with random idling on both channels and one stretch with no idling.
// ---------------------------------------------------------------------------

module spectrum_cyclic_bin_shift_tb;
    import scbs_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PERCENT = 24;
    // Mode 3 has no name of its own; bit 1 makes it a cosine average.
    localparam logic [MODE_W-1:0] MODE_UNUSED = MODE_COS | MODE_BWD;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;

    // Bench copy of the registers and the bin store.
    logic [WIN_W-1:0]              cfg_window = WINDOW_RESET;
    logic [SHIFT_W-1:0]            cfg_shift = SHIFT_RESET;
    logic [MODE_W-1:0]             cfg_mode = MODE_FWD;
    logic signed [SAMPLE_BITS-1:0] bin_re [MAX_BINS];
    logic signed [SAMPLE_BITS-1:0] bin_im [MAX_BINS];
    logic                          bin_loaded [MAX_BINS];

    // Read results still owed by the block, oldest first.
    t_out_item expected_bins [$];

    bit steady = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned n_fail = 0;
    int unsigned n_checked = 0;
    int unsigned n_loads = 0;
    int unsigned n_reads = 0;
    int unsigned n_err_reads = 0;
    int unsigned n_configs = 0;

    spectrum_cyclic_bin_shift u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results owed", cycle_count,
                     expected_bins.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Random back-pressure on the result channel.
    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        n_fail++;
        $display("Mismatch in %s of result %0d: got %0d, expected %0d",
                 what, n_checked, got, want);
    endtask

    // Inputs only change at the rising edge, so the values seen at the falling
    // edge are the ones the next rising edge will act on.
    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bins.size() == 0) begin
                report_mismatch("unexpected result re", o_out_item.out_re, 0);
            end else begin
                want = expected_bins.pop_front();
                if (o_out_item.out_re !== want.out_re)
                    report_mismatch("out_re", o_out_item.out_re, want.out_re);
                if (o_out_item.out_im !== want.out_im)
                    report_mismatch("out_im", o_out_item.out_im, want.out_im);
                if (o_out_item.error !== want.error)
                    report_mismatch("error", o_out_item.error, want.error);
            end
            n_checked++;
        end
    end

    // True when a read of bin k is served under the current registers.
    function automatic bit serves_read(input int unsigned k);
        int unsigned n;
        n = cfg_window;
        return n >= 2 && n <= MAX_BINS && k < n && cfg_shift < n;
    endfunction

    // Expected answer to a read of output bin k.
    function automatic t_out_item shifted_bin(input int unsigned k);
        t_out_item res;
        int unsigned n, s, fwd, bwd;
        logic signed [SAMPLE_BITS:0] sum_re, sum_im;
        res = '0;
        n = cfg_window;
        s = cfg_shift;
        if (!serves_read(k)) begin
            res.error = 1'b1;
            return res;
        end
        fwd = (k + n - s) % n;
        bwd = (k + s) % n;
        if (cfg_mode == MODE_FWD) begin
            res.out_re = bin_re[fwd];
            res.out_im = bin_im[fwd];
        end else if (cfg_mode == MODE_BWD) begin
            res.out_re = bin_re[bwd];
            res.out_im = bin_im[bwd];
        end else begin
            // Dropping the low bit of the wide sum is the floor of the half.
            sum_re = bin_re[fwd] + bin_re[bwd];
            sum_im = bin_im[fwd] + bin_im[bwd];
            res.out_re = sum_re[SAMPLE_BITS:1];
            res.out_im = sum_im[SAMPLE_BITS:1];
        end
        return res;
    endfunction

    // Offer one request, hold it until taken, then update the prediction.
    task automatic send_request(input t_in_item req);
        int unsigned gap;
        bit taken;
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        if (req.op == OP_LOAD) begin
            bin_re[req.bin_index]     = req.sample_re;
            bin_im[req.bin_index]     = req.sample_im;
            bin_loaded[req.bin_index] = 1'b1;
            n_loads++;
        end else begin
            expected_bins.push_back(shifted_bin(req.bin_index));
            n_reads++;
            if (!serves_read(req.bin_index))
                n_err_reads++;
        end
    endtask

    task automatic send_load(input int unsigned k, input logic [SAMPLE_BITS-1:0] re,
                             input logic [SAMPLE_BITS-1:0] im);
        t_in_item req;
        req.op        = OP_LOAD;
        req.bin_index = BIN_W'(k);
        req.sample_re = re;
        req.sample_im = im;
        send_request(req);
    endtask

    task automatic ensure_loaded(input int unsigned k);
        if (!bin_loaded[k])
            send_load(k, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    endtask

    // Read request; any store entry it would touch is loaded first.
    task automatic send_read(input int unsigned k);
        t_in_item req;
        int unsigned n, s;
        n = cfg_window;
        s = cfg_shift;
        if (serves_read(k)) begin
            if (cfg_mode != MODE_BWD)
                ensure_loaded((k + n - s) % n);
            if (cfg_mode != MODE_FWD)
                ensure_loaded((k + s) % n);
        end
        req.op        = OP_READ;
        req.bin_index = BIN_W'(k);
        req.sample_re = SAMPLE_BITS'($urandom);
        req.sample_im = SAMPLE_BITS'($urandom);
        send_request(req);
    endtask

    // Stop sending, wait for every owed result, then let the pipeline empty.
    task automatic settle_block;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [WIN_W-1:0] win, input logic [SHIFT_W-1:0] shift,
                              input logic [MODE_W-1:0] mode_code);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WINDOW_SIZE;
        i_cfg_data  <= CFG_DATA_W'(win);
        @(posedge i_clk);
        i_cfg_index <= CFG_SHIFT_BINS;
        i_cfg_data  <= CFG_DATA_W'(shift);
        @(posedge i_clk);
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= CFG_DATA_W'(mode_code);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_window = win;
        cfg_shift  = shift;
        cfg_mode   = mode_code;
        n_configs++;
    endtask

    // Often small windows, else any valid size, now and then the extremes or an invalid size.
    task automatic set_random_config;
        logic [WIN_W-1:0] win;
        logic [SHIFT_W-1:0] shift;
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            win = WIN_W'(2);
        else if (sel == 1)
            win = WIN_W'(MAX_BINS);
        else if (sel == 2)
            win = WIN_W'($urandom_range(0, 1));
        else if (sel == 3)
            win = WIN_W'($urandom_range(MAX_BINS + 1, (1 << WIN_W) - 1));
        else if (sel < 12)
            win = WIN_W'($urandom_range(2, 32));
        else
            win = WIN_W'($urandom_range(2, MAX_BINS));
        sel = $urandom_range(0, 9);
        if (sel == 0 || win < 2 || win > MAX_BINS)
            shift = SHIFT_W'($urandom_range(0, MAX_BINS - 1));
        else if (sel == 1)
            shift = SHIFT_W'(win - 1);
        else
            shift = SHIFT_W'($urandom_range(0, win - 1));
        set_config(win, shift, MODE_W'($urandom_range(0, 3)));
    endtask

    task automatic run_random_phase(input int unsigned n_items);
        int unsigned n, span, pick, k;
        set_random_config();
        n = cfg_window;
        span = (n >= 2 && n <= MAX_BINS) ? n : MAX_BINS;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_BINS - 1)
                                                : $urandom_range(0, span - 1);
                send_load(k, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
            end else if (pick < 90) begin
                send_read($urandom_range(0, span - 1));
            end else begin
                send_read($urandom_range(0, MAX_BINS - 1));
            end
        end
    endtask

    // Registers at reset: full window, no shift, forward mode.
    task automatic test_reset_defaults;
        send_load(0, 16'sh8000, 16'sh7FFF);
        send_load(MAX_BINS - 1, 16'sh7FFF, 16'sh8000);
        send_read(0);
        send_read(MAX_BINS - 1);
    endtask

    // Small window: wrap-around in both directions and the cosine average,
    // including a negative odd sum that must round toward minus infinity.
    task automatic test_wrap_and_modes;
        set_config(4, 1, MODE_FWD);
        send_load(0, 16'sh7FFF, 16'sh8000);
        send_load(1, 16'sh8000, 16'shFFFF);
        send_load(2, 16'sh0001, 16'sh0000);
        send_load(3, 16'shFFFF, 16'sh8000);
        send_read(0);
        send_read(3);
        set_config(4, 1, MODE_BWD);
        send_read(3);
        set_config(4, 1, MODE_COS);
        send_read(0);
        send_read(1);
        set_config(4, 1, MODE_UNUSED);
        send_read(0);
    endtask

    // Bin or shift outside the window and invalid window sizes.
    task automatic test_error_cases;
        set_config(4, 1, MODE_FWD);
        send_read(4);
        send_read(MAX_BINS - 1);
        set_config(4, 4, MODE_FWD);
        send_read(0);
        set_config(MAX_BINS, MAX_BINS - 1, MODE_BWD);
        send_read(0);
        set_config(0, 0, MODE_FWD);
        send_read(0);
        set_config(1, 0, MODE_FWD);
        send_read(0);
        set_config(MAX_BINS + 1, 0, MODE_FWD);
        send_read(0);
        set_config((1 << WIN_W) - 1, 0, MODE_FWD);
        send_read(0);
        set_config(2, 1, MODE_COS);
        send_read(0);
        send_read(1);
    endtask

    task automatic test_random_phases;
        repeat (8) run_random_phase(28);
    endtask

    // One long stretch with both channels always ready.
    task automatic test_back_to_back;
        steady = 1'b1;
        run_random_phase(64);
        settle_block();
        steady = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < MAX_BINS; i++) begin
            bin_re[i]     = '0;
            bin_im[i]     = '0;
            bin_loaded[i] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_wrap_and_modes();
        test_error_cases();
        test_random_phases();
        test_back_to_back();
        settle_block();

        $display("Sent %0d loads and %0d reads (%0d refused with error) over %0d settings.",
                 n_loads, n_reads, n_err_reads, n_configs);
        $display("Checked %0d results in order with random idling on both channels.",
                 n_checked);
        if (n_fail == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
